/* design/potp_pkg.sv */
`default_nettype none

package potp_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_CREATE = 3'd1,
    MODE_START  = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_DELETE = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_CREATED  = 3'd0,
    ST_ZERO     = 3'd1,
    ST_FULL     = 3'd2,
    ST_INVALID  = 3'd3,
    ST_DONE     = 3'd4,
    ST_FIRED    = 3'd5,
    ST_TICKDONE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_TDONE
  } state_t;

endpackage

`default_nettype wire

/* design/periodic_oneshot_timer_pool.sv */
`default_nettype none

// channel   direction  handshake         payload
// command   in         start / busy      mode, slot, period, periodic
// result    out        strobe            status, timer_slot, reloaded, tick_count, last
//
// create, stop, delete and rejected commands: result registered in the cycle after accept
// start: period read from memory at accept, result registered from S_START
// tick: busy through S_SCAN and S_TDONE, one read of the slot memories per slot
// rst clears all slot flags and the tick count; slot memories need no clear
// the receiver cannot stall: each result shows for one cycle with strobe high

module periodic_oneshot_timer_pool (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [2:0]  slot,
  input  logic [31:0] period,
  input  logic        periodic,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [2:0]  timer_slot,
  output logic        reloaded,
  output logic [31:0] tick_count,
  output logic        last
);
  import potp_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  state_t state, state_next;

  logic [31:0]            ticks, ticks_next;
  logic [TIMER_SLOTS-1:0] slot_used, slot_used_next;
  logic [TIMER_SLOTS-1:0] slot_armed, slot_armed_next;
  logic [TIMER_SLOTS-1:0] slot_periodic, slot_periodic_next;
  logic [SLOT_W-1:0]      scan, scan_next;
  logic [SLOT_W-1:0]      pidx, pidx_next;
  logic [SLOT_W-1:0]      cmd_slot, cmd_slot_next;
  logic                   issuing, issuing_next;
  logic                   pvalid, pvalid_next;

  logic        res_strobe, res_strobe_next;
  logic [2:0]  res_status, res_status_next;
  logic [2:0]  res_slot, res_slot_next;
  logic        res_reloaded, res_reloaded_next;
  logic        res_last, res_last_next;

  logic [31:0]       period_mem    [TIMER_SLOTS];
  logic [31:0]       remaining_mem [TIMER_SLOTS];
  logic [31:0]       per_q, rem_q;
  logic              rd_en, per_we, rem_we;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic [31:0]       rem_wdata;

  logic              accept;
  logic [SLOT_W-1:0] sidx;
  logic              slot_ok, target_used;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              p_active, p_fire;
  logic [31:0]       dec;

  assign accept      = start && !busy;
  assign sidx        = SLOT_W'(slot);
  assign slot_ok     = {29'd0, slot} < 32'(TIMER_SLOTS);
  assign target_used = slot_ok && slot_used[sidx];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign p_active = pvalid && slot_used[pidx] && slot_armed[pidx];
  assign dec      = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
  assign p_fire   = p_active && (dec == 32'd0);

  // slot memories
  always_ff @(posedge clk) begin
    if (rd_en) begin
      per_q <= period_mem[rd_addr];
      rem_q <= remaining_mem[rd_addr];
    end
    if (per_we) begin
      period_mem[wr_addr] <= period;
    end
    if (rem_we) begin
      remaining_mem[wr_addr] <= rem_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_TICK) begin
            state_next = S_SCAN;
          end else if (mode == MODE_START && target_used) begin
            state_next = S_START;
          end
        end
      end
      S_START: state_next = S_IDLE;
      S_SCAN: begin
        if (pvalid && pidx == LAST_SLOT) begin
          state_next = S_TDONE;
        end
      end
      S_TDONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    ticks_next         = ticks;
    slot_used_next     = slot_used;
    slot_armed_next    = slot_armed;
    slot_periodic_next = slot_periodic;
    scan_next          = scan;
    pidx_next          = pidx;
    cmd_slot_next      = cmd_slot;
    issuing_next       = issuing;
    pvalid_next        = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = '0;
    per_we             = 1'b0;
    rem_we             = 1'b0;
    wr_addr            = '0;
    rem_wdata          = period;
    res_strobe_next    = 1'b0;
    res_status_next    = res_status;
    res_slot_next      = res_slot;
    res_reloaded_next  = 1'b0;
    res_last_next      = res_last;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_last_next = 1'b1;
          case (mode)
            MODE_TICK: begin
              ticks_next   = ticks + 32'd1;
              scan_next    = '0;
              issuing_next = 1'b1;
            end
            MODE_CREATE: begin
              res_strobe_next = 1'b1;
              res_slot_next   = 3'd0;
              if (period == 32'd0) begin
                res_status_next = ST_ZERO;
              end else if (!free_found) begin
                res_status_next = ST_FULL;
              end else begin
                per_we                       = 1'b1;
                rem_we                       = 1'b1;
                wr_addr                      = free_idx;
                rem_wdata                    = period;
                slot_used_next[free_idx]     = 1'b1;
                slot_armed_next[free_idx]    = 1'b0;
                slot_periodic_next[free_idx] = periodic;
                res_status_next              = ST_CREATED;
                res_slot_next                = 3'(free_idx);
              end
            end
            MODE_START: begin
              if (target_used) begin
                rd_en         = 1'b1;
                rd_addr       = sidx;
                cmd_slot_next = sidx;
              end else begin
                res_strobe_next = 1'b1;
                res_status_next = ST_INVALID;
                res_slot_next   = slot;
              end
            end
            MODE_STOP, MODE_DELETE: begin
              res_strobe_next = 1'b1;
              res_slot_next   = slot;
              if (target_used) begin
                slot_armed_next[sidx] = 1'b0;
                if (mode == MODE_DELETE) begin
                  slot_used_next[sidx] = 1'b0;
                end
                res_status_next = ST_DONE;
              end else begin
                res_status_next = ST_INVALID;
              end
            end
            default: begin
              res_strobe_next = 1'b1;
              res_status_next = ST_INVALID;
              res_slot_next   = slot;
            end
          endcase
        end
      end
      S_START: begin
        rem_we                    = 1'b1;
        wr_addr                   = cmd_slot;
        rem_wdata                 = per_q;
        slot_armed_next[cmd_slot] = 1'b1;
        res_strobe_next           = 1'b1;
        res_status_next           = ST_DONE;
        res_slot_next             = 3'(cmd_slot);
        res_last_next             = 1'b1;
      end
      S_SCAN: begin
        // read slot scan while slot pidx is updated
        if (issuing) begin
          rd_en       = 1'b1;
          rd_addr     = scan;
          pvalid_next = 1'b1;
          pidx_next   = scan;
          if (scan == LAST_SLOT) begin
            issuing_next = 1'b0;
          end else begin
            scan_next = scan + SLOT_W'(1);
          end
        end
        if (p_active) begin
          rem_we    = 1'b1;
          wr_addr   = pidx;
          rem_wdata = (p_fire && slot_periodic[pidx]) ? per_q : dec;
        end
        if (p_fire) begin
          if (!slot_periodic[pidx]) begin
            slot_armed_next[pidx] = 1'b0;
          end
          res_strobe_next   = 1'b1;
          res_status_next   = ST_FIRED;
          res_slot_next     = 3'(pidx);
          res_reloaded_next = slot_periodic[pidx];
          res_last_next     = 1'b0;
        end
      end
      S_TDONE: begin
        res_strobe_next = 1'b1;
        res_status_next = ST_TICKDONE;
        res_slot_next   = 3'd0;
        res_last_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ticks         <= 32'd0;
      slot_used     <= '0;
      slot_armed    <= '0;
      slot_periodic <= '0;
      issuing       <= 1'b0;
      pvalid        <= 1'b0;
      res_strobe    <= 1'b0;
    end else begin
      state         <= state_next;
      ticks         <= ticks_next;
      slot_used     <= slot_used_next;
      slot_armed    <= slot_armed_next;
      slot_periodic <= slot_periodic_next;
      issuing       <= issuing_next;
      pvalid        <= pvalid_next;
      res_strobe    <= res_strobe_next;
    end
    scan         <= scan_next;
    pidx         <= pidx_next;
    cmd_slot     <= cmd_slot_next;
    res_status   <= res_status_next;
    res_slot     <= res_slot_next;
    res_reloaded <= res_reloaded_next;
    res_last     <= res_last_next;
  end

  assign busy       = (state != S_IDLE);
  assign strobe     = res_strobe;
  assign status     = res_status;
  assign timer_slot = res_slot;
  assign reloaded   = res_reloaded;
  assign tick_count = ticks;
  assign last       = res_last;

`ifndef SYNTHESIS
  a_busy_ends_with_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> strobe && last)
    else $error("busy dropped without final result");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_FIRED |-> !last)
    else $error("fired result marked last");

  a_ticks_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ticks != $past(ticks) |-> ticks == $past(ticks) + 32'd1)
    else $error("tick count jumped");

  a_armed_used: assert property (@(posedge clk) disable iff (rst)
    (slot_armed & ~slot_used) == '0)
    else $error("armed timer on free slot");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import potp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = TIMER_SLOTS + 8;
  localparam int PRINT_LIMIT = 40;
  localparam int RANDOM_ITEMS = 270;

  // undefined command codes
  localparam logic [2:0] MODE_RSVD_A = 3'd5;
  localparam logic [2:0] MODE_RSVD_B = 3'd6;
  localparam logic [2:0] MODE_RSVD_C = 3'd7;

  typedef struct {
    status_t     status;
    logic [2:0]  timer_slot;
    logic        reloaded;
    logic [31:0] tick_count;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  mode = '0;
  logic [2:0]  slot = '0;
  logic [31:0] period = '0;
  logic        periodic = 1'b0;
  logic        busy;
  logic        strobe;
  logic [2:0]  status;
  logic [2:0]  timer_slot;
  logic        reloaded;
  logic [31:0] tick_count;
  logic        last;

  periodic_oneshot_timer_pool u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .slot       (slot),
    .period     (period),
    .periodic   (periodic),
    .strobe     (strobe),
    .status     (status),
    .timer_slot (timer_slot),
    .reloaded   (reloaded),
    .tick_count (tick_count),
    .last       (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // mirror of the timer pool
  bit          pool_used [TIMER_SLOTS];
  bit          pool_armed [TIMER_SLOTS];
  bit          pool_reload [TIMER_SLOTS];
  logic [31:0] pool_period [TIMER_SLOTS];
  logic [31:0] pool_remaining [TIMER_SLOTS];
  logic [31:0] pool_ticks = '0;

  timer_result_t pending_results[$];
  int errors = 0;
  int burst_left = 0;

  function automatic void queue_result(status_t st, logic [2:0] sl, logic rl, logic lst);
    timer_result_t r;
    r.status = st;
    r.timer_slot = sl;
    r.reloaded = rl;
    r.tick_count = pool_ticks;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_timer_results(logic [2:0] m, logic [2:0] s,
                                                logic [31:0] p, logic k);
    bit found;
    found = 0;
    if (m == MODE_TICK) begin
      pool_ticks = pool_ticks + 32'd1;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (pool_used[i] && pool_armed[i]) begin
          if (pool_remaining[i] != 0) pool_remaining[i] = pool_remaining[i] - 32'd1;
          if (pool_remaining[i] == 0) begin
            if (pool_reload[i]) pool_remaining[i] = pool_period[i];
            else pool_armed[i] = 0;
            queue_result(ST_FIRED, i[2:0], pool_reload[i], 1'b0);
          end
        end
      end
      queue_result(ST_TICKDONE, 3'd0, 1'b0, 1'b1);
    end else if (m == MODE_CREATE) begin
      if (p == 0) begin
        queue_result(ST_ZERO, 3'd0, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!found && !pool_used[i]) begin
            found = 1;
            pool_used[i] = 1;
            pool_armed[i] = 0;
            pool_reload[i] = k;
            pool_period[i] = p;
            pool_remaining[i] = p;
            queue_result(ST_CREATED, i[2:0], 1'b0, 1'b1);
          end
        end
        if (!found) queue_result(ST_FULL, 3'd0, 1'b0, 1'b1);
      end
    end else if ((m == MODE_START || m == MODE_STOP || m == MODE_DELETE) &&
                 int'(s) < TIMER_SLOTS && pool_used[s]) begin
      if (m == MODE_START) begin
        pool_remaining[s] = pool_period[s];
        pool_armed[s] = 1;
      end else if (m == MODE_STOP) begin
        pool_armed[s] = 0;
      end else begin
        pool_armed[s] = 0;
        pool_used[s] = 0;
      end
      queue_result(ST_DONE, s, 1'b0, 1'b1);
    end else begin
      queue_result(ST_INVALID, s, 1'b0, 1'b1);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic check_result();
    timer_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, status", 32'(status), 32'd0);
    end else begin
      want = pending_results.pop_front();
      if (status !== want.status)
        report_mismatch("status", 32'(status), 32'(want.status));
      if (timer_slot !== want.timer_slot)
        report_mismatch("timer_slot", 32'(timer_slot), 32'(want.timer_slot));
      if (reloaded !== want.reloaded)
        report_mismatch("reloaded", 32'(reloaded), 32'(want.reloaded));
      if (tick_count !== want.tick_count)
        report_mismatch("tick_count", tick_count, want.tick_count);
      if (last !== want.last)
        report_mismatch("last", 32'(last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_timer_results(mode, slot, period, periodic);
      if (strobe) check_result();
    end
  end

  task automatic send_item(input logic [2:0] m, input logic [2:0] s,
                           input logic [31:0] p, input logic k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    mode <= m;
    slot <= s;
    period <= p;
    periodic <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_empty_pool();
    send_item(MODE_TICK, 3'd0, 32'd0, 1'b0);
    send_item(MODE_START, 3'd3, 32'd0, 1'b0);
    send_item(MODE_STOP, 3'd5, 32'd0, 1'b0);
    send_item(MODE_DELETE, 3'd7, 32'd0, 1'b0);
    send_item(MODE_RSVD_A, 3'd2, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_RSVD_B, 3'd6, 32'd1, 1'b0);
    send_item(MODE_RSVD_C, 3'd1, 32'd7, 1'b1);
  endtask

  task automatic test_create_and_fill();
    send_item(MODE_CREATE, 3'd4, 32'd0, 1'b1);
    send_item(MODE_CREATE, 3'd0, 32'd1, 1'b1);
    send_item(MODE_CREATE, 3'd0, 32'd2, 1'b0);
    send_item(MODE_CREATE, 3'd7, 32'hFFFF_FFFF, 1'b1);
    for (int i = 3; i < TIMER_SLOTS; i++)
      send_item(MODE_CREATE, 3'd0, 32'd3, i[0]);
    send_item(MODE_CREATE, 3'd0, 32'd9, 1'b0);
  endtask

  task automatic test_fire_and_release();
    send_item(MODE_START, 3'd0, 32'd0, 1'b0);
    send_item(MODE_START, 3'd1, 32'd0, 1'b0);
    send_item(MODE_START, 3'd2, 32'd0, 1'b0);
    send_item(MODE_TICK, 3'd0, 32'd0, 1'b0);
    send_item(MODE_TICK, 3'd0, 32'd0, 1'b0);
    send_item(MODE_STOP, 3'd0, 32'd0, 1'b0);
    send_item(MODE_DELETE, 3'd1, 32'd0, 1'b0);
    send_item(MODE_TICK, 3'd0, 32'd0, 1'b0);
  endtask

  function automatic logic [2:0] pick_slot();
    logic [2:0] cand;
    for (int tries = 0; tries < 8; tries++) begin
      cand = 3'($urandom_range(0, TIMER_SLOTS - 1));
      if (pool_used[cand]) return cand;
    end
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'($urandom_range(1, 5));
    if (r < 80) return 32'($urandom_range(6, 40));
    if (r < 90) return 32'($urandom);
    return 32'd0;
  endfunction

  task automatic test_random_traffic();
    int r;
    logic [2:0] s;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      s = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : pick_slot();
      if (r < 35)
        send_item(MODE_TICK, 3'($urandom), 32'($urandom), 1'($urandom));
      else if (r < 53)
        send_item(MODE_CREATE, 3'($urandom), pick_period(), 1'($urandom));
      else if (r < 73)
        send_item(MODE_START, s, 32'($urandom), 1'($urandom));
      else if (r < 82)
        send_item(MODE_STOP, s, 32'($urandom), 1'($urandom));
      else if (r < 97)
        send_item(MODE_DELETE, s, 32'($urandom), 1'($urandom));
      else
        send_item(3'($urandom_range(5, 7)), s, 32'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pool();
    test_create_and_fill();
    test_fire_and_release();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
